### rtl/exact_fill_knapsack_min_max_defines.svh
// ----------------------------------------------------------------------------
// Exact-fill knapsack assertion macros
// Shared property wrappers for the concurrent checks of the knapsack block.
// ----------------------------------------------------------------------------
`ifndef EXACT_FILL_KNAPSACK_MIN_MAX_DEFINES_SVH
`define EXACT_FILL_KNAPSACK_MIN_MAX_DEFINES_SVH

// Checked on every clock edge outside reset
`define EFK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define EFK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/efk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-fill knapsack package
// Field widths, input kinds, defaults and shared types of the knapsack block.
// ----------------------------------------------------------------------------
package efk_pkg;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int VALUE_BITS = 16;
  localparam int WEIGHT_W   = 11;
  localparam int TOTAL_W    = 26;

  // Parameter defaults
  localparam int MAX_TYPES_DEF  = 64;
  localparam int MAX_WEIGHT_DEF = 1024;

  // Largest total the result fields carry
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  // One stored item type
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [WEIGHT_W-1:0]   weight;
  } type_entry_t;

  // Commands to the item type table
  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
  } type_cmd_t;

endpackage

### rtl/efk_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-fill knapsack channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface efk_in_if;
  logic                              valid;
  logic                              ready;
  logic [efk_pkg::KIND_W-1:0]        kind;
  logic [efk_pkg::VALUE_BITS-1:0]    item_value;
  logic [efk_pkg::WEIGHT_W-1:0]      item_weight;

  modport source (output valid, kind, item_value, item_weight, input ready);
  modport sink   (input valid, kind, item_value, item_weight, output ready);
endinterface

interface efk_out_if;
  logic                           valid;
  logic                           ready;
  logic [efk_pkg::TOTAL_W-1:0]    min_total;
  logic [efk_pkg::TOTAL_W-1:0]    max_total;
  logic                           reachable;

  modport source (output valid, min_total, max_total, reachable, input ready);
  modport sink   (input valid, min_total, max_total, reachable, output ready);
endinterface

### rtl/efk_type_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-fill knapsack item type table
// Holds the loaded item types and their count; one registered read port.
// ----------------------------------------------------------------------------
module efk_type_table #(
  parameter int MAX_TYPES = efk_pkg::MAX_TYPES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  efk_pkg::type_cmd_t       cmd,
  input  efk_pkg::type_entry_t     wr_entry,
  input  logic [((MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1)-1:0] rd_addr,
  output efk_pkg::type_entry_t     rd_data,
  output logic [$clog2(MAX_TYPES+1)-1:0] count
);

  localparam int TI_W  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int CNT_W = $clog2(MAX_TYPES+1);

  efk_pkg::type_entry_t mem [MAX_TYPES];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_en;

  // Loads past a full table are dropped
  assign wr_en = cmd.load && (count_r < CNT_W'(MAX_TYPES));

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Storage: write at the fill point, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[TI_W-1:0]] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign count = count_r;

endmodule

### rtl/efk_dp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-fill knapsack weight table
// Per-weight {reachable, least total, greatest total}; one write, one read.
// ----------------------------------------------------------------------------
module efk_dp_table #(
  parameter int DEPTH = efk_pkg::MAX_WEIGHT_DEF + 1,
  parameter int ENT_W = 2 * (11 + efk_pkg::VALUE_BITS) + 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ENT_W-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ENT_W-1:0]         rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/exact_fill_knapsack_min_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-fill unbounded knapsack, least and greatest total value
// Loads item types, then fills the configured target weight exactly.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : kind 0 loads an item type (item_value, item_weight), kind 1
//            starts a compute, kind 2 empties the type table, kind 3 is
//            ignored. Loads after the table is full are dropped.
//   out_ch : one item per compute: min_total, max_total, reachable.
//   cfg_we / cfg_wdata : target weight, to be written only while the block
//            is idle; the block itself does not enforce this.
//   Loads and clears are accepted while idle and may come back to back.
//   A compute writes weight entry 0 in a setup step, then runs weight 1
//   up to the target; each weight steps through the N loaded types, with
//   one type table read and one weight table read issued per cycle, and
//   drains before its entry is written. Targets of 0 or above MAX_WEIGHT
//   skip the weight loop and go straight to the output state.
// Reset clears the type count, the target and the output; the tables need
// no clearing. The result waits in an output register while the receiver
// stalls; loads, clears and a further compute go on, whose result waits.
// ----------------------------------------------------------------------------
`include "exact_fill_knapsack_min_max_defines.svh"

module exact_fill_knapsack_min_max #(
  parameter int MAX_TYPES  = efk_pkg::MAX_TYPES_DEF,
  parameter int MAX_WEIGHT = efk_pkg::MAX_WEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efk_in_if.sink                        in_ch,
  efk_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [efk_pkg::WEIGHT_W-1:0]  cfg_wdata
);

  localparam int WI_W   = $clog2(MAX_WEIGHT + 1);
  localparam int TI_W   = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int CNT_W  = $clog2(MAX_TYPES + 1);
  localparam int VB     = efk_pkg::VALUE_BITS;
  localparam int WW     = efk_pkg::WEIGHT_W;
  localparam int TOT_W  = WI_W + VB;
  localparam int ENT_W  = 2 * TOT_W + 1;
  localparam int WCMP_W = (WI_W > WW) ? WI_W : WW;
  localparam int SAT_W  = (TOT_W > efk_pkg::TOTAL_W) ? TOT_W : efk_pkg::TOTAL_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [WW-1:0]    target_r;
  logic [WI_W-1:0]  w_r, w_nxt;
  logic [TI_W-1:0]  i_r, i_nxt;
  logic             t_v_r, t_v_nxt;
  logic             d_v_r, d_v_nxt;
  logic             d_skip_r, d_skip_nxt;
  logic [VB-1:0]    d_val_r, d_val_nxt;
  logic             any_r, any_nxt;
  logic [TOT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [TOT_W-1:0] res_min_r, res_min_nxt, res_max_r, res_max_nxt;
  logic             res_reach_r, res_reach_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [efk_pkg::TOTAL_W-1:0] out_min_r, out_max_r;
  logic             out_reach_r;

  logic             in_acc, is_compute, flush_done, load_out, last_type;
  logic [WI_W-1:0]  tgt_idx, prev;
  logic             skip;
  logic [TOT_W-1:0] cand_lo, cand_hi;
  logic [SAT_W-1:0] ext_min, ext_max;

  efk_pkg::type_cmd_t   ty_cmd;
  efk_pkg::type_entry_t ty_wr, ty_q;
  logic [CNT_W-1:0]     type_count;

  logic             dp_we;
  logic [WI_W-1:0]  dp_waddr;
  logic [ENT_W-1:0] dp_wdata, dp_q;
  logic             dp_q_valid;
  logic [TOT_W-1:0] dp_q_min, dp_q_max;

  // Handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_compute  = in_ch.kind == efk_pkg::KIND_COMPUTE;
  assign tgt_idx     = WI_W'(target_r);

  // Item type table
  assign ty_cmd.load  = in_acc && (in_ch.kind == efk_pkg::KIND_LOAD);
  assign ty_cmd.clear = in_acc && (in_ch.kind == efk_pkg::KIND_CLEAR);
  assign ty_cmd.rd_en = (state_r == S_RUN) && (type_count != '0);
  assign ty_wr.value  = in_ch.item_value;
  assign ty_wr.weight = in_ch.item_weight;

  efk_type_table #(
    .MAX_TYPES (MAX_TYPES)
  ) u_types (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ty_cmd),
    .wr_entry (ty_wr),
    .rd_addr  (i_r),
    .rd_data  (ty_q),
    .count    (type_count)
  );

  // Stage 1: type entry in hand, look up the weight it builds on
  assign skip = (ty_q.weight == '0) || (WCMP_W'(ty_q.weight) > WCMP_W'(w_r));
  assign prev = w_r - WI_W'(ty_q.weight);

  // Weight table write: entry 0 at setup, entry w once its reads are done
  assign flush_done = (state_r == S_DRAIN) && !t_v_r && !d_v_r;
  assign dp_we      = (state_r == S_INIT) || flush_done;
  assign dp_waddr   = (state_r == S_INIT) ? '0 : w_r;
  assign dp_wdata   = (state_r == S_INIT) ? {1'b1, {(2 * TOT_W){1'b0}}} :
                      {any_r, (any_r ? lo_r : '0), (any_r ? hi_r : '0)};

  efk_dp_table #(
    .DEPTH (MAX_WEIGHT + 1),
    .ENT_W (ENT_W)
  ) u_dp (
    .clk   (clk),
    .we    (dp_we),
    .waddr (dp_waddr),
    .wdata (dp_wdata),
    .re    (t_v_r),
    .raddr (prev),
    .rdata (dp_q)
  );

  assign {dp_q_valid, dp_q_min, dp_q_max} = dp_q;

  // Stage 2: candidates from the earlier weight
  assign cand_lo = dp_q_min + TOT_W'(d_val_r);
  assign cand_hi = dp_q_max + TOT_W'(d_val_r);

  assign last_type = (CNT_W'(i_r) + CNT_W'(1)) == type_count;
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Sequencer and accumulators
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    i_nxt         = i_r;
    t_v_nxt       = 1'b0;
    d_v_nxt       = t_v_r;
    d_skip_nxt    = skip;
    d_val_nxt     = ty_q.value;
    any_nxt       = any_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_min_nxt   = res_min_r;
    res_max_nxt   = res_max_r;
    res_reach_nxt = res_reach_r;

    if (d_v_r && !d_skip_r && dp_q_valid) begin
      if (!any_r || (cand_lo < lo_r)) begin
        lo_nxt = cand_lo;
      end
      if (!any_r || (cand_hi > hi_r)) begin
        hi_nxt = cand_hi;
      end
      any_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_compute) begin
          res_min_nxt = '0;
          res_max_nxt = '0;
          if (target_r == '0) begin
            res_reach_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else if (32'(target_r) > 32'(MAX_WEIGHT)) begin
            res_reach_nxt = 1'b0;
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        w_nxt     = WI_W'(1);
        i_nxt     = '0;
        any_nxt   = 1'b0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        t_v_nxt = (type_count != '0);
        if ((type_count == '0) || last_type) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + TI_W'(1);
        end
      end
      S_DRAIN: begin
        if (flush_done) begin
          any_nxt = 1'b0;
          i_nxt   = '0;
          if (w_r == tgt_idx) begin
            res_min_nxt   = any_r ? lo_r : '0;
            res_max_nxt   = any_r ? hi_r : '0;
            res_reach_nxt = any_r;
            state_nxt     = S_OUT;
          end else begin
            w_nxt     = w_r + WI_W'(1);
            state_nxt = S_RUN;
          end
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      target_r <= '0;
      t_v_r    <= 1'b0;
      d_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t_v_r   <= t_v_nxt;
      d_v_r   <= d_v_nxt;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    i_r         <= i_nxt;
    d_skip_r    <= d_skip_nxt;
    d_val_r     <= d_val_nxt;
    any_r       <= any_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    res_min_r   <= res_min_nxt;
    res_max_r   <= res_max_nxt;
    res_reach_r <= res_reach_nxt;
  end

  // Output register with saturation to the field width
  assign ext_min       = SAT_W'(res_min_r);
  assign ext_max       = SAT_W'(res_max_r);
  assign out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_min_r   <= (ext_min > SAT_W'(efk_pkg::TOTAL_MAX)) ? efk_pkg::TOTAL_MAX :
                     ext_min[efk_pkg::TOTAL_W-1:0];
      out_max_r   <= (ext_max > SAT_W'(efk_pkg::TOTAL_MAX)) ? efk_pkg::TOTAL_MAX :
                     ext_max[efk_pkg::TOTAL_W-1:0];
      out_reach_r <= res_reach_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_total = out_min_r;
  assign out_ch.max_total = out_max_r;
  assign out_ch.reachable = out_reach_r;

  // Checks
  `EFK_ASSERT(a_count_bound, type_count <= CNT_W'(MAX_TYPES), "type count beyond table size")
  `EFK_ASSERT(a_compute_busy, (in_acc && is_compute) |=> !in_ch.ready, "compute did not hold input")
  `EFK_ASSERT(a_weight_range, (state_r == S_RUN) |-> ((w_r != '0) && (w_r <= tgt_idx)), "weight index out of range")
  `EFK_ASSERT_RST(a_reset_out, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule
